/* sv/wgit_pkg.sv */
// ----------------------------------------------------------------------------
// wgit_pkg
// Shared types and the binary16 add/subtract function of the input-tile
// transform.
// ----------------------------------------------------------------------------
package wgit_pkg;

   localparam int HALF_W = 16;
   localparam int ROWS   = 4;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [15:0] QNAN_DEFAULT = 16'h7E00;
   localparam logic [15:0] INF_POS      = 16'h7C00;

   typedef logic [HALF_W-1:0] half_type;

   // one full tile handed from the front part to the back part
   typedef struct packed {
      half_type [3:0] r0;
      half_type [3:0] r1;
      half_type [3:0] r2;
      half_type [3:0] r3;
   } tile_type;

   // status that travels from the back part to the top level
   typedef struct packed {
      logic       busy;
      logic [1:0] row;
   } back_status_type;

   // Round a positive magnitude in units of 2^-24 (below 2^41) to binary16.
   function automatic logic [14:0] round_mag(input logic [40:0] v);
      logic [5:0]  p;
      logic [5:0]  sh;
      logic [40:0] mant;
      logic [40:0] rem;
      logic [40:0] halfway;
      logic [15:0] bits;
      p = 6'd0;
      for (int k = 0; k < 41; k++) begin
         if (v[k]) begin
            p = 6'(k);
         end
      end
      if (v < 41'd1024) begin
         round_mag = 15'(v);
      end else if (p == 6'd10) begin
         round_mag = 15'(v);
      end else begin
         sh = p - 6'd10;
         mant = v >> sh;
         rem = v & ((41'd1 << sh) - 41'd1);
         halfway = 41'd1 << (sh - 6'd1);
         if (rem > halfway || (rem == halfway && mant[0])) begin
            mant = mant + 41'd1;
         end
         bits = {sh, 10'd0} + 16'(mant);
         if (bits >= 16'h7C00) begin
            bits = 16'h7C00;
         end
         round_mag = bits[14:0];
      end
   endfunction

   // finite magnitude in units of 2^-24
   function automatic logic [39:0] half_mag(input half_type h);
      if (h[14:10] == 5'd0) begin
         half_mag = {30'd0, h[9:0]};
      end else begin
         half_mag = 40'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
      end
   endfunction

   // a + b, or a - b when sub is set, round to nearest even
   function automatic half_type h_addsub(input half_type a, input half_type b,
                                         input logic sub);
      logic        a_nan;
      logic        b_nan;
      half_type    bb;
      logic [39:0] ma;
      logic [39:0] mb;
      logic [40:0] s;
      a_nan = (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
      b_nan = (b[14:10] == 5'h1F) && (b[9:0] != 10'd0);
      bb = {b[15] ^ sub, b[14:0]};
      ma = half_mag(a);
      mb = half_mag(b);
      if (a_nan) begin
         h_addsub = a | 16'h0200;
      end else if (b_nan) begin
         h_addsub = b | 16'h0200;
      end else if (a[14:0] == INF_POS[14:0]) begin
         if (bb[14:0] == INF_POS[14:0] && a[15] != bb[15]) begin
            h_addsub = QNAN_DEFAULT;
         end else begin
            h_addsub = a;
         end
      end else if (bb[14:0] == INF_POS[14:0]) begin
         h_addsub = bb;
      end else if (a[15] == bb[15]) begin
         s = {1'b0, ma} + {1'b0, mb};
         if (s == 41'd0) begin
            h_addsub = {a[15], 15'd0};
         end else begin
            h_addsub = {a[15], round_mag(s)};
         end
      end else if (ma == mb) begin
         h_addsub = 16'd0;
      end else if (ma > mb) begin
         h_addsub = {a[15], round_mag({1'b0, ma - mb})};
      end else begin
         h_addsub = {bb[15], round_mag({1'b0, mb - ma})};
      end
   endfunction

endpackage

/* sv/wgit_front.sv */
// ----------------------------------------------------------------------------
// wgit_front
// Collects three rows of a tile, then runs the column pass on the fourth and
// hands the intermediate tile on.
// ----------------------------------------------------------------------------
module wgit_front
   import wgit_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  half_type req_elem_a,
   input  half_type req_elem_b,
   input  half_type req_elem_c,
   input  half_type req_elem_d,
   input  logic     full,
   output logic     req_stall,
   output logic     push,
   output tile_type push_tile
);

   logic [1:0]     row_count_ff;
   logic [1:0]     row_count_in;
   half_type [3:0] store_ff [3];
   half_type [3:0] cur;
   logic           accept;

   assign cur = {req_elem_d, req_elem_c, req_elem_b, req_elem_a};
   // the fourth row needs room in the queue
   assign req_stall = (row_count_ff == 2'd3) && full;
   assign accept = req_valid && !req_stall;
   assign push = accept && (row_count_ff == 2'd3);
   assign row_count_in = accept ? row_count_ff + 2'd1 : row_count_ff;

   // advance the row count
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 2'd0;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   // hold the first three rows
   always_ff @(posedge clock) begin
      if (accept && row_count_ff != 2'd3) begin
         store_ff[row_count_ff] <= cur;
      end
   end

   // column pass, one pattern per column
   always_comb begin
      for (int j = 0; j < ROWS; j++) begin
         push_tile.r0[j] = h_addsub(store_ff[0][j], store_ff[2][j], 1'b1);
         push_tile.r1[j] = h_addsub(store_ff[1][j], store_ff[2][j], 1'b0);
         push_tile.r2[j] = h_addsub(store_ff[2][j], store_ff[1][j], 1'b1);
         push_tile.r3[j] = h_addsub(store_ff[1][j], cur[j], 1'b1);
      end
   end

endmodule

/* sv/wgit_queue.sv */
// ----------------------------------------------------------------------------
// wgit_queue
// Short tile queue between the front and back parts.
// ----------------------------------------------------------------------------
module wgit_queue
   import wgit_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  tile_type push_tile,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output tile_type head
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   tile_type        mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff;
   logic [PW-1:0]   wr_in;
   logic [PW-1:0]   rd_ff;
   logic [PW-1:0]   rd_in;
   logic [PW:0]     cnt_ff;
   logic [PW:0]     cnt_in;

   assign full  = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rd_ff];
   assign wr_in = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // write entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_tile;
      end
   end

endmodule

/* sv/wgit_back.sv */
// ----------------------------------------------------------------------------
// wgit_back
// Runs the row pass on one intermediate row per cycle, while the output is
// not stalled, into an output register.
// ----------------------------------------------------------------------------
module wgit_back
   import wgit_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            empty,
   input  tile_type        head,
   input  logic            rsp_stall,
   output logic            pop,
   output logic            rsp_valid,
   output half_type        rsp_res_a,
   output half_type        rsp_res_b,
   output half_type        rsp_res_c,
   output half_type        rsp_res_d,
   output logic [1:0]      rsp_out_row,
   output logic            rsp_last_row,
   output back_status_type status
);

   logic [1:0]     row_ff;
   logic [1:0]     row_in;
   logic           valid_ff;
   logic           valid_in;
   half_type [3:0] data_ff;
   half_type [3:0] data_in;
   logic [1:0]     orow_ff;
   half_type [3:0] q;
   logic           load;

   // output register frees when empty or taken
   assign load = !empty && (!valid_ff || !rsp_stall);
   assign pop = load && row_ff == 2'd3;
   assign row_in = load ? row_ff + 2'd1 : row_ff;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   // select the current intermediate row
   always_comb begin
      case (row_ff)
         2'd0: q = head.r0;
         2'd1: q = head.r1;
         2'd2: q = head.r2;
         2'd3: q = head.r3;
         default: q = head.r0;
      endcase
      data_in[0] = h_addsub(q[0], q[2], 1'b1);
      data_in[1] = h_addsub(q[1], q[2], 1'b0);
      data_in[2] = h_addsub(q[2], q[1], 1'b1);
      data_in[3] = h_addsub(q[1], q[3], 1'b1);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         orow_ff <= row_ff;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res_a    = data_ff[0];
   assign rsp_res_b    = data_ff[1];
   assign rsp_res_c    = data_ff[2];
   assign rsp_res_d    = data_ff[3];
   assign rsp_out_row  = orow_ff;
   assign rsp_last_row = orow_ff == 2'd3;
   assign status.busy  = valid_ff;
   assign status.row   = row_ff;

endmodule

/* sv/winograd_input_tile_transform.sv */
// ----------------------------------------------------------------------------
// winograd_input_tile_transform
// Binary16 Winograd F(2x2,3x3) input transform, one tile row per request.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless req_stall is raised; four requests in give four results out.
// The fourth row of a tile is registered in the queue, then its results in the output register.
// The front part runs the column pass, a four-tile queue decouples it from
// the back part, which runs the row pass one result row per cycle while not stalled.
// Reset clears row counters, queue pointers and the output valid.
module winograd_input_tile_transform
   import wgit_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  half_type req_elem_a,
   input  half_type req_elem_b,
   input  half_type req_elem_c,
   input  half_type req_elem_d,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output half_type rsp_res_a,
   output half_type rsp_res_b,
   output half_type rsp_res_c,
   output half_type rsp_res_d,
   output logic [1:0] rsp_out_row,
   output logic     rsp_last_row
);

   logic            push;
   logic            pop;
   logic            full;
   logic            empty;
   tile_type        push_tile;
   tile_type        head;
   back_status_type status;

   wgit_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_elem_a(req_elem_a), .req_elem_b(req_elem_b),
      .req_elem_c(req_elem_c), .req_elem_d(req_elem_d),
      .full(full), .req_stall(req_stall), .push(push), .push_tile(push_tile)
   );

   wgit_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_tile(push_tile),
      .pop(pop), .full(full), .empty(empty), .head(head)
   );

   wgit_back u_back (
      .clock(clock), .reset(reset), .empty(empty), .head(head),
      .rsp_stall(rsp_stall), .pop(pop), .rsp_valid(rsp_valid),
      .rsp_res_a(rsp_res_a), .rsp_res_b(rsp_res_b), .rsp_res_c(rsp_res_c),
      .rsp_res_d(rsp_res_d), .rsp_out_row(rsp_out_row),
      .rsp_last_row(rsp_last_row), .status(status)
   );

   // a tile leaves the queue only after its last row is produced
   a_pop_last: assert property (@(posedge clock) disable iff (reset)
      pop |-> status.row == 2'd3)
      else $error("tile popped before its last row");

   // the queue never overflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   // a loaded result row follows the back part's row order
   a_row_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_row) ##1 rsp_valid
      |-> rsp_out_row == $past(rsp_out_row) + 2'd1)
      else $error("result rows out of order");

   // a stalled result stays valid
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      (status.busy && rsp_stall) |=> status.busy)
      else $error("stalled result dropped");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the binary16 Winograd F(2x2,3x3) input tile transform. It
// streams tile rows with random sender gaps and receiver stalls and compares
// every result row with an independent predictor of the transform.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wgit_pkg::*;

   typedef struct {
      half_type   v [4];
      logic [1:0] row;
      logic       last;
   } tile_row_type;

   // Round a positive magnitude (units of 2^-24) to a binary16 magnitude.
   function automatic logic [15:0] pack_mag(input longint unsigned v);
      int unsigned     p;
      int unsigned     shift;
      longint unsigned mant;
      longint unsigned rem;
      longint unsigned halfway;
      longint unsigned t;
      longint unsigned bits;
      if (v < 1024) return 16'(v);
      p = 0;
      t = v;
      while (t > 1) begin
         t = t >> 1;
         p++;
      end
      shift = p - 10;
      if (shift == 0) return 16'(v);
      mant = v >> shift;
      rem = v & ((64'd1 << shift) - 1);
      halfway = 64'd1 << (shift - 1);
      if (rem > halfway || (rem == halfway && mant[0])) mant++;
      bits = (longint'(shift) << 10) + mant;
      if (bits >= 64'h7C00) bits = 64'h7C00;
      return 16'(bits);
   endfunction

   function automatic longint unsigned mag_of(input logic [15:0] h);
      if (h[14:10] == 0) return longint'(h[9:0]);
      return longint'({1'b1, h[9:0]}) << (h[14:10] - 1);
   endfunction

   // Binary16 add, or subtract when sub is set.
   function automatic logic [15:0] half_sum(input logic [15:0] a,
                                            input logic [15:0] b, input logic sub);
      longint unsigned ma;
      longint unsigned mb;
      if (a[14:10] == 5'h1F && a[9:0] != 0) return a | 16'h0200;
      if (b[14:10] == 5'h1F && b[9:0] != 0) return b | 16'h0200;
      if (sub) b[15] = ~b[15];
      if (a[14:0] == 15'h7C00) begin
         if (b[14:0] == 15'h7C00 && a[15] != b[15]) return 16'h7E00;
         return a;
      end
      if (b[14:0] == 15'h7C00) return b;
      ma = mag_of(a);
      mb = mag_of(b);
      if (a[15] == b[15]) begin
         if (ma + mb == 0) return {a[15], 15'd0};
         return {a[15], 15'd0} | pack_mag(ma + mb);
      end
      if (ma == mb) return 16'd0;
      if (ma > mb) return {a[15], 15'd0} | pack_mag(ma - mb);
      return {b[15], 15'd0} | pack_mag(mb - ma);
   endfunction

   typedef logic [15:0] quad_type [4];

   function automatic quad_type bt_pattern(input quad_type q);
      quad_type r;
      r[0] = half_sum(q[0], q[2], 1'b1);
      r[1] = half_sum(q[1], q[2], 1'b0);
      r[2] = half_sum(q[2], q[1], 1'b1);
      r[3] = half_sum(q[1], q[3], 1'b1);
      return r;
   endfunction

   class tile_scoreboard;
      half_type     held [3][4];
      int           rows_held;
      tile_row_type pending [$];
      int           errors;
      int           rows_checked;

      // note an accepted request; the fourth row yields four expected rows
      function void note_request(input half_type e [4]);
         quad_type x [4];
         quad_type t [4];
         quad_type col;
         quad_type res;
         tile_row_type tr;
         if (rows_held < 3) begin
            held[rows_held] = e;
            rows_held++;
            return;
         end
         rows_held = 0;
         for (int i = 0; i < 3; i++) x[i] = held[i];
         x[3] = e;
         for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 4; i++) col[i] = x[i][j];
            res = bt_pattern(col);
            for (int i = 0; i < 4; i++) t[i][j] = res[i];
         end
         for (int i = 0; i < 4; i++) begin
            tr.v = bt_pattern(t[i]);
            tr.row = 2'(i);
            tr.last = (i == 3);
            pending.push_back(tr);
         end
      endfunction

      function void check_row(input tile_row_type got);
         tile_row_type want;
         rows_checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result row %0d", $time, got.row);
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int j = 0; j < 4; j++)
            if (got.v[j] !== want.v[j]) begin
               $display("%0t: col %0d expected %h actual %h", $time, j,
                        want.v[j], got.v[j]);
               errors++;
            end
         if (got.row !== want.row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_row expected %0d actual %0d", $time, want.last,
                     got.last);
            errors++;
         end
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   half_type req_elem_a = '0, req_elem_b = '0, req_elem_c = '0, req_elem_d = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b1;
   half_type rsp_res_a, rsp_res_b, rsp_res_c, rsp_res_d;
   logic [1:0] rsp_out_row;
   logic     rsp_last_row;

   int send_idle_pct = 29;
   int stall_pct = 80;
   int requests_sent;
   tile_scoreboard board = new();

   winograd_input_tile_transform u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // randomize receiver stall
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // check every accepted result row
   always @(posedge clock) begin
      tile_row_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.v[0] = rsp_res_a;
         got.v[1] = rsp_res_b;
         got.v[2] = rsp_res_c;
         got.v[3] = rsp_res_d;
         got.row = rsp_out_row;
         got.last = rsp_last_row;
         board.check_row(got);
      end
   end

   // note every accepted request
   always @(posedge clock) begin
      half_type e [4];
      if (!reset && req_valid && !req_stall) begin
         e[0] = req_elem_a;
         e[1] = req_elem_b;
         e[2] = req_elem_c;
         e[3] = req_elem_d;
         board.note_request(e);
      end
   end

   // pick a binary16 pattern, biased toward special encodings
   function automatic half_type pick_half();
      case ($urandom_range(9))
         0: return {1'($urandom), 15'h7C00};
         1: return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
         2: return {1'($urandom), 5'd0, 10'($urandom)};
         3: return {1'($urandom), 15'd0};
         4: return {1'($urandom), 5'h1E, 10'($urandom)};
         5: return {1'($urandom), 5'($urandom_range(13, 17)), 10'($urandom)};
         default: return 16'($urandom);
      endcase
   endfunction

   // send one request, idling first at random
   task automatic send_row(input half_type a, b, c, d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elem_a <= a;
      req_elem_b <= b;
      req_elem_c <= c;
      req_elem_d <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_tile(input half_type t [16]);
      for (int i = 0; i < 4; i++)
         send_row(t[4*i], t[4*i+1], t[4*i+2], t[4*i+3]);
   endtask

   initial begin
      half_type t [16];
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // all zeros, all ones, max finite, infinities, NaNs, subnormals
      foreach (t[k]) t[k] = 16'h0000;
      send_tile(t);
      foreach (t[k]) t[k] = 16'hFFFF;
      send_tile(t);
      foreach (t[k]) t[k] = (k % 2) ? 16'h7BFF : 16'hFBFF;
      send_tile(t);
      foreach (t[k]) t[k] = (k % 3 == 0) ? 16'h7C00 : ((k % 3 == 1) ? 16'hFC00 : 16'h8000);
      send_tile(t);
      foreach (t[k]) t[k] = (k % 2) ? 16'h0001 : 16'h83FF;
      send_tile(t);
      foreach (t[k]) t[k] = (k % 4 == 1) ? 16'hFD55 : 16'h3C00 + 16'(k);
      send_tile(t);
      // random tiles in three idling phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 29 : ((ph == 1) ? 80 : 0);
         stall_pct = (ph == 0) ? 80 : ((ph == 1) ? 29 : 0);
         for (int n = 0; n < 12; n++) begin
            foreach (t[k]) t[k] = ($urandom_range(3) == 0) ? 16'($urandom) : pick_half();
            send_tile(t);
         end
      end
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d tile rows (%0d tiles), checked %0d result rows", requests_sent,
               requests_sent / 4, board.rows_checked);
      $display("Covered signed zeros, infinities, NaNs, subnormals and overflow");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
